// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the heap sorter.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IRHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/irhs_pkg.sv -----
// Shared types and constants of the interval record heap sorter.
// No dependencies; the other design files but assert_macros.svh refer to it by scoped names.
package irhs_pkg;

	localparam int FIELD_BITS     = 31;
	localparam int CAPACITY_DEF   = 64;
	localparam int TIME_BITS_DEF  = 31;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_BUILD_CHK,
		ST_B_FETCH,
		ST_B_TAKE,
		ST_B_CHILD,
		ST_B_CMP,
		ST_X_RD,
		ST_X_SWAP,
		ST_X_CHILD,
		ST_X_CMP,
		ST_E_RD,
		ST_E_PUT
	} irhs_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;       // take an input beat into the record store
		logic build_init;  // size heap, set build cursor, rewind emit index
		logic fetch;       // read the next build root
		logic take_a;      // hold the sifting record from read port A
		logic child_rd;    // read both children of the current node
		logic cmp_step;    // pick the larger child, write, descend
		logic bk_dec;      // step the build cursor down
		logic xrd;         // read root and last heap slot
		logic xswap;       // move root to last slot, shrink heap
		logic emit_rd;     // read the next sorted record
		logic emit_load;   // fill the output register
		logic clear;       // end of run: empty the set
	} irhs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sink_done;   // current node already outranks its children
		logic bk_one;      // build cursor at its final root
		logic heap_gt1;    // more than one record left in the heap
		logic few;         // fewer than two records held
		logic emit_last;   // emit index points at the final record
		logic out_free;    // output register can take a record
	} irhs_stat_t;

endpackage

// ----- design/irhs_in_if.sv -----
// Input channel of the heap sorter: one interval record per beat.
// Depends on irhs_pkg for the field width.
interface irhs_in_if;
	logic                            valid;
	logic                            ready;
	logic [irhs_pkg::FIELD_BITS-1:0] start_time;
	logic [irhs_pkg::FIELD_BITS-1:0] end_time;
	logic                            last;

	modport source (output valid, output start_time, output end_time, output last,
		input ready);
	modport sink (input valid, input start_time, input end_time, input last,
		output ready);
endinterface

// ----- design/irhs_out_if.sv -----
// Output channel of the heap sorter: one sorted record per beat.
// Depends on irhs_pkg for the field width.
interface irhs_out_if;
	logic                            valid;
	logic                            ready;
	logic [irhs_pkg::FIELD_BITS-1:0] sorted_start;
	logic [irhs_pkg::FIELD_BITS-1:0] sorted_end;
	logic                            final_record;
	logic                            overflowed;

	modport source (output valid, output sorted_start, output sorted_end,
		output final_record, output overflowed, input ready);
	modport sink (input valid, input sorted_start, input sorted_end,
		input final_record, input overflowed, output ready);
endinterface

// ----- design/irhs_dpath.sv -----
// Datapath of the heap sorter: record memory, sift compare, counters, output register.
// Depends on irhs_pkg for command and status types.
module irhs_dpath #(
	parameter int CAPACITY  = irhs_pkg::CAPACITY_DEF,
	parameter int TIME_BITS = irhs_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  irhs_pkg::irhs_cmd_t             cmd,
	output irhs_pkg::irhs_stat_t            stat,
	input  logic [irhs_pkg::FIELD_BITS-1:0] start_time,
	input  logic [irhs_pkg::FIELD_BITS-1:0] end_time,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [irhs_pkg::FIELD_BITS-1:0] sorted_start,
	output logic [irhs_pkg::FIELD_BITS-1:0] sorted_end,
	output logic                            final_record,
	output logic                            overflowed
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = CW + 1;
	localparam int RW = 2 * TIME_BITS;
	localparam int FB = irhs_pkg::FIELD_BITS;

	// record = {start, end}
	logic [RW-1:0] mem [CAPACITY];
	logic [RW-1:0] rd_a_q, rd_b_q, v_q;
	logic [CW-1:0] count_q, heap_q, bk_q;
	logic [IW-1:0] node_q, emit_q;
	logic          ovf_q, out_valid_q;
	logic [FB-1:0] out_start_q, out_end_q;
	logic          out_final_q, out_ovf_q;

	logic          full, rd_en, wr_en;
	logic [IW-1:0] rd_a_addr, rd_b_addr, wr_addr, bk_idx, heap_last, next_node;
	logic [RW-1:0] wr_data, bigv1, bigval;
	logic [XW-1:0] lc_x, rc_x;
	logic          lc_ok, rc_ok, pick_l, pick_r, sink_done, emit_last;

	function automatic logic rec_less(input logic [RW-1:0] a, input logic [RW-1:0] b);
		logic [TIME_BITS-1:0] a_end, b_end, a_start, b_start;
		a_end   = a[TIME_BITS-1:0];
		b_end   = b[TIME_BITS-1:0];
		a_start = a[RW-1:TIME_BITS];
		b_start = b[RW-1:TIME_BITS];
		return (a_end < b_end) || ((a_end == b_end) && (a_start > b_start));
	endfunction

	assign full      = (count_q == CW'(CAPACITY));
	assign bk_idx    = IW'(bk_q - CW'(1));
	assign heap_last = IW'(heap_q - CW'(1));

	// Sift step: ties count as larger, right child wins over an equal left.
	assign lc_x      = XW'({node_q, 1'b0}) + XW'(1);
	assign rc_x      = XW'({node_q, 1'b0}) + XW'(2);
	assign lc_ok     = lc_x < XW'(heap_q);
	assign rc_ok     = rc_x < XW'(heap_q);
	assign pick_l    = lc_ok && !rec_less(rd_a_q, v_q);
	assign bigv1     = pick_l ? rd_a_q : v_q;
	assign pick_r    = rc_ok && !rec_less(rd_b_q, bigv1);
	assign bigval    = pick_r ? rd_b_q : bigv1;
	assign sink_done = !pick_l && !pick_r;
	assign next_node = pick_r ? rc_x[IW-1:0] : lc_x[IW-1:0];

	assign emit_last = ((CW'(emit_q) + CW'(1)) == count_q);

	// Memory ports
	assign rd_en     = cmd.fetch | cmd.child_rd | cmd.xrd | cmd.emit_rd;
	assign rd_a_addr = cmd.fetch ? bk_idx :
		cmd.child_rd ? lc_x[IW-1:0] :
		cmd.emit_rd ? emit_q : '0;
	assign rd_b_addr = cmd.child_rd ? rc_x[IW-1:0] : heap_last;

	assign wr_en   = (cmd.store && !full) || cmd.cmp_step || cmd.xswap;
	assign wr_addr = cmd.store ? count_q[IW-1:0] : (cmd.xswap ? heap_last : node_q);
	assign wr_data = cmd.store ? {start_time[TIME_BITS-1:0], end_time[TIME_BITS-1:0]} :
		cmd.xswap ? rd_a_q :
		(sink_done ? v_q : bigval);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_a_addr];
			rd_b_q <= mem[rd_b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.build_init) begin
			heap_q <= count_q;
			bk_q   <= count_q >> 1;
			emit_q <= '0;
		end
		if (cmd.fetch) begin
			node_q <= bk_idx;
		end
		if (cmd.bk_dec) begin
			bk_q <= bk_q - CW'(1);
		end
		if (cmd.take_a) begin
			v_q <= rd_a_q;
		end
		if (cmd.xrd) begin
			node_q <= '0;
		end
		if (cmd.xswap) begin
			v_q    <= rd_b_q;
			heap_q <= heap_q - CW'(1);
		end
		if (cmd.cmp_step && !sink_done) begin
			node_q <= next_node;
		end
		if (cmd.emit_load) begin
			emit_q      <= emit_q + IW'(1);
			out_start_q <= FB'(rd_a_q[RW-1:TIME_BITS]);
			out_end_q   <= FB'(rd_a_q[TIME_BITS-1:0]);
			out_final_q <= emit_last;
			out_ovf_q   <= ovf_q;
		end
	end

	always_comb begin
		stat           = '0;
		stat.sink_done = sink_done;
		stat.bk_one    = (bk_q == CW'(1));
		stat.heap_gt1  = (heap_q > CW'(1));
		stat.few       = (count_q < CW'(2));
		stat.emit_last = emit_last;
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign sorted_start = out_start_q;
	assign sorted_end   = out_end_q;
	assign final_record = out_final_q;
	assign overflowed   = out_ovf_q;

endmodule

// ----- design/irhs_ctrl.sv -----
// Controller of the heap sorter: sequences load, heap build, extraction and emit.
// Depends on irhs_pkg for the state, command and status types.
module irhs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	output logic                 in_ready,
	input  irhs_pkg::irhs_stat_t stat,
	output irhs_pkg::irhs_cmd_t  cmd
);

	irhs_pkg::irhs_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irhs_pkg::ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			irhs_pkg::ST_LOAD: begin
				if (in_valid && in_last) begin
					state_nx = irhs_pkg::ST_BUILD_CHK;
				end
			end
			irhs_pkg::ST_BUILD_CHK: begin
				state_nx = stat.few ? irhs_pkg::ST_E_RD : irhs_pkg::ST_B_FETCH;
			end
			irhs_pkg::ST_B_FETCH: state_nx = irhs_pkg::ST_B_TAKE;
			irhs_pkg::ST_B_TAKE:  state_nx = irhs_pkg::ST_B_CMP;
			irhs_pkg::ST_B_CHILD: state_nx = irhs_pkg::ST_B_CMP;
			irhs_pkg::ST_B_CMP: begin
				if (!stat.sink_done) begin
					state_nx = irhs_pkg::ST_B_CHILD;
				end else if (stat.bk_one) begin
					state_nx = irhs_pkg::ST_X_RD;
				end else begin
					state_nx = irhs_pkg::ST_B_FETCH;
				end
			end
			irhs_pkg::ST_X_RD:    state_nx = irhs_pkg::ST_X_SWAP;
			irhs_pkg::ST_X_SWAP:  state_nx = irhs_pkg::ST_X_CMP;
			irhs_pkg::ST_X_CHILD: state_nx = irhs_pkg::ST_X_CMP;
			irhs_pkg::ST_X_CMP: begin
				if (!stat.sink_done) begin
					state_nx = irhs_pkg::ST_X_CHILD;
				end else if (stat.heap_gt1) begin
					state_nx = irhs_pkg::ST_X_RD;
				end else begin
					state_nx = irhs_pkg::ST_E_RD;
				end
			end
			irhs_pkg::ST_E_RD: state_nx = irhs_pkg::ST_E_PUT;
			irhs_pkg::ST_E_PUT: begin
				if (stat.out_free) begin
					state_nx = stat.emit_last ? irhs_pkg::ST_LOAD : irhs_pkg::ST_E_RD;
				end
			end
			default: state_nx = irhs_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			irhs_pkg::ST_LOAD: begin
				in_ready  = 1'b1;
				cmd.store = in_valid;
			end
			irhs_pkg::ST_BUILD_CHK: cmd.build_init = 1'b1;
			irhs_pkg::ST_B_FETCH:   cmd.fetch = 1'b1;
			irhs_pkg::ST_B_TAKE: begin
				cmd.take_a   = 1'b1;
				cmd.child_rd = 1'b1;
			end
			irhs_pkg::ST_B_CHILD: cmd.child_rd = 1'b1;
			irhs_pkg::ST_B_CMP: begin
				cmd.cmp_step = 1'b1;
				cmd.bk_dec   = stat.sink_done;
			end
			irhs_pkg::ST_X_RD: cmd.xrd = 1'b1;
			irhs_pkg::ST_X_SWAP: begin
				cmd.xswap    = 1'b1;
				cmd.child_rd = 1'b1;
			end
			irhs_pkg::ST_X_CHILD: cmd.child_rd = 1'b1;
			irhs_pkg::ST_X_CMP:   cmd.cmp_step = 1'b1;
			irhs_pkg::ST_E_RD:    cmd.emit_rd = 1'b1;
			irhs_pkg::ST_E_PUT: begin
				cmd.emit_load = stat.out_free;
				cmd.clear     = stat.out_free && stat.emit_last;
			end
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- design/interval_record_heap_sorter.sv -----
// Top level of the interval record heap sorter: controller plus datapath.
// Depends on irhs_pkg, irhs_in_if, irhs_out_if, irhs_ctrl and irhs_dpath.
//
// Send interval records (start, end) on the records channel, one per beat, and
// mark the final record of a set with last. Record beats are taken while the
// block is loading, with ready held high. Up to CAPACITY records are kept;
// further beats of the set are dropped and every result of that run then
// carries overflowed. On the last beat the block stops taking records,
// heap-sorts the set in place and returns it on the sorted channel ascending by
// end time, equal end times by descending start time, with final_record on the
// closing beat. Timing is set by the record memory (one write and two
// registered reads per cycle) and by a sift step that reads both children in
// one state and compares and writes in the next. A build sift fetches its root
// and takes it, an extraction reads the root and last slot and swaps them, and
// each then descends one level per step until a final compare finds the node in
// place. A set of n records is loaded and the heap sized, then built by n/2
// sifts and sorted by n - 1 extractions; a set of fewer than two skips both.
// Each result is read and then put in the output register; that step waits
// while the previous result is stalled there. The records channel reopens as
// soon as the final result sits in the output register. Only the low TIME_BITS
// bits of each time are kept.
module interval_record_heap_sorter #(
	parameter int CAPACITY  = irhs_pkg::CAPACITY_DEF,
	parameter int TIME_BITS = irhs_pkg::TIME_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	irhs_in_if.sink     records,
	irhs_out_if.source  sorted
);

	irhs_pkg::irhs_cmd_t  cmd;
	irhs_pkg::irhs_stat_t stat;

	// Sequence the phases; take record beats only while loading.
	irhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (records.valid),
		.in_last  (records.last),
		.in_ready (records.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold records, run the sift compares and drive the output register.
	irhs_dpath #(
		.CAPACITY  (CAPACITY),
		.TIME_BITS (TIME_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.start_time   (records.start_time),
		.end_time     (records.end_time),
		.out_ready    (sorted.ready),
		.out_valid    (sorted.valid),
		.sorted_start (sorted.sorted_start),
		.sorted_end   (sorted.sorted_end),
		.final_record (sorted.final_record),
		.overflowed   (sorted.overflowed)
	);

endmodule

// ----- design/irhs_checker.sv -----
// Port-level checks of the heap sorter and their bind to the top level.
// Depends on assert_macros.svh and irhs_pkg.
`include "assert_macros.svh"

module irhs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            records_valid,
	input logic                            records_ready,
	input logic                            records_last,
	input logic                            sorted_valid,
	input logic                            sorted_ready,
	input logic [irhs_pkg::FIELD_BITS-1:0] sorted_start,
	input logic [irhs_pkg::FIELD_BITS-1:0] sorted_end,
	input logic                            sorted_final,
	input logic                            sorted_ovf
);

	// A stalled result beat holds.
	`IRHS_ASSERT_NEXT(a_out_hold, clk, arst_n, sorted_valid && !sorted_ready, sorted_valid && $stable(sorted_start) && $stable(sorted_end) && $stable(sorted_final) && $stable(sorted_ovf), "stalled result changed")

	// No record beat is taken while a run is still being emitted.
	`IRHS_ASSERT_NOW(a_no_load_mid_run, clk, arst_n, sorted_valid && !sorted_final, !records_ready, "record taken in mid run")

	// The closing record of a set starts the sort.
	`IRHS_ASSERT_NEXT(a_last_closes, clk, arst_n, records_valid && records_ready && records_last, !records_ready, "ready after last beat")

	// Loading continues after an ordinary record.
	`IRHS_ASSERT_NEXT(a_load_stays, clk, arst_n, records_valid && records_ready && !records_last, records_ready, "ready dropped while loading")

endmodule

bind interval_record_heap_sorter irhs_checker u_irhs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.records_valid (records.valid),
	.records_ready (records.ready),
	.records_last  (records.last),
	.sorted_valid  (sorted.valid),
	.sorted_ready  (sorted.ready),
	.sorted_start  (sorted.sorted_start),
	.sorted_end    (sorted.sorted_end),
	.sorted_final  (sorted.final_record),
	.sorted_ovf    (sorted.overflowed)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for interval_record_heap_sorter.
// Depends on irhs_pkg, irhs_in_if, irhs_out_if and the design top level.
// Drives record sets, predicts each sorted run with a heap sort of its own.
module tb;

	localparam int          CAPACITY    = irhs_pkg::CAPACITY_DEF;
	localparam int          TBITS       = irhs_pkg::FIELD_BITS;
	localparam logic [30:0] TIME_MAX    = 31'h7fff_ffff;
	localparam int          TOTAL_ITEMS = 220;
	localparam int          HOLD_CYCLES = 500;
	localparam int          HOLD_AFTER  = 40;
	localparam int          PLAN_LEN    = 22;

	typedef struct packed {
		logic [TBITS-1:0] arrive;
		logic [TBITS-1:0] depart;
	} interval_t;

	typedef struct packed {
		logic [TBITS-1:0] arrive;
		logic [TBITS-1:0] depart;
		logic             final_rec;
		logic             ovf;
	} sorted_rec_t;

	// One row of the directed table; want holds a typed-in result for single-record sets.
	typedef struct packed {
		logic [TBITS-1:0] arrive;
		logic [TBITS-1:0] depart;
		logic             last;
		logic             pinned;
		sorted_rec_t      want;
	} plan_row_t;

	typedef struct {
		int          item_no;
		sorted_rec_t want;
	} pinned_t;

	logic clk = 1'b0;
	logic arst_n;

	irhs_in_if  rec_if();
	irhs_out_if srt_if();

	interval_record_heap_sorter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.records(rec_if),
		.sorted (srt_if)
	);

	always #1 clk = ~clk;

	// Shared bookkeeping between driver, consumer and monitor.
	sorted_rec_t sorted_q[$];   // expected sorted beats, oldest first
	pinned_t     pinned_q[$];   // typed-in results of directed single-record sets
	int          errors        = 0;
	int          items_sent    = 0;
	int          items_taken   = 0;
	int          results_taken = 0;
	bit          calm          = 1'b0;  // when set, neither side idles at random

	// Predictor copy of the block state.
	interval_t held[CAPACITY];
	int        held_cnt = 0;
	bit        held_ovf = 1'b0;

	// Directed table: extremes after reset with typed results, then small sets that
	// exercise ties on end time, duplicates, presorted and reversed input.
	plan_row_t plan[PLAN_LEN] = '{
		'{31'd0,        31'd0,        1'b1, 1'b1, '{31'd0,        31'd0,        1'b1, 1'b0}},
		'{TIME_MAX,     TIME_MAX,     1'b1, 1'b1, '{TIME_MAX,     TIME_MAX,     1'b1, 1'b0}},
		'{TIME_MAX,     31'd0,        1'b1, 1'b1, '{TIME_MAX,     31'd0,        1'b1, 1'b0}},
		'{31'd0,        TIME_MAX,     1'b1, 1'b1, '{31'd0,        TIME_MAX,     1'b1, 1'b0}},
		'{31'h2aaaaaaa, 31'h55555555, 1'b1, 1'b1, '{31'h2aaaaaaa, 31'h55555555, 1'b1, 1'b0}},
		'{31'd5,        31'd10,       1'b0, 1'b0, '0},
		'{31'd7,        31'd10,       1'b0, 1'b0, '0},
		'{31'd3,        31'd2,        1'b0, 1'b0, '0},
		'{TIME_MAX,     31'd0,        1'b0, 1'b0, '0},
		'{31'd0,        TIME_MAX,     1'b0, 1'b0, '0},
		'{31'd7,        31'd10,       1'b0, 1'b0, '0},
		'{31'd9,        31'd10,       1'b1, 1'b0, '0},
		'{31'd1,        31'd1,        1'b0, 1'b0, '0},
		'{31'd2,        31'd2,        1'b1, 1'b0, '0},
		'{31'd4,        31'd9,        1'b0, 1'b0, '0},
		'{31'd3,        31'd8,        1'b0, 1'b0, '0},
		'{31'd2,        31'd7,        1'b0, 1'b0, '0},
		'{31'd1,        31'd6,        1'b0, 1'b0, '0},
		'{31'd0,        31'd5,        1'b1, 1'b0, '0},
		'{31'd6,        31'd6,        1'b0, 1'b0, '0},
		'{31'd6,        31'd6,        1'b0, 1'b0, '0},
		'{31'd6,        31'd6,        1'b1, 1'b0, '0}
	};

	// --- Queue helpers ---

	// Append one expected sorted beat at the tail.
	function automatic void queue_expected(input sorted_rec_t r);
		sorted_q.insert(sorted_q.size(), r);
	endfunction

	// Append one typed-in result, tied to the item number that closes its set.
	function automatic void queue_pin(input int item_no, input sorted_rec_t want);
		pinned_t p;
		p.item_no = item_no;
		p.want    = want;
		pinned_q.insert(pinned_q.size(), p);
	endfunction

	// --- Predictor: heap sort of the held set, same sift order as the block ---

	// Record a goes ahead of record b: lower end time, or equal end and later start.
	function automatic bit goes_ahead(int a, int b);
		if (held[a].depart != held[b].depart)
			return held[a].depart < held[b].depart;
		return held[a].arrive > held[b].arrive;
	endfunction

	function automatic void swap_held(int a, int b);
		interval_t t;
		t       = held[a];
		held[a] = held[b];
		held[b] = t;
	endfunction

	// Push node down until it outranks both children; ties move the child up.
	function automatic void sift_down(int node, int size);
		int lc, rc, big;
		while (1) begin
			lc  = 2 * node + 1;
			rc  = 2 * node + 2;
			big = node;
			if (lc < size && !goes_ahead(lc, node))
				big = lc;
			if (rc < size && !goes_ahead(rc, big))
				big = rc;
			if (big == node)
				return;
			swap_held(node, big);
			node = big;
		end
	endfunction

	function automatic void heap_sort_held(int n);
		int k, heap;
		heap = n;
		for (k = n / 2; k > 0; k--)
			sift_down(k - 1, n);
		while (heap > 1) begin
			swap_held(0, heap - 1);
			heap--;
			sift_down(0, heap);
		end
	endfunction

	// Absorb one accepted record beat; on the last beat queue the whole sorted run.
	function automatic void take_record(interval_t rec, logic is_last);
		int      k;
		pinned_t pin;
		if (held_cnt < CAPACITY) begin
			held[held_cnt] = rec;
			held_cnt++;
		end else begin
			held_ovf = 1'b1;
		end
		if (is_last) begin
			heap_sort_held(held_cnt);
			if (pinned_q.size() != 0 && pinned_q[0].item_no == items_taken) begin
				pin = pinned_q.pop_front();
				queue_expected(pin.want);
			end else begin
				for (k = 0; k < held_cnt; k++)
					queue_expected('{held[k].arrive, held[k].depart,
						k == held_cnt - 1, held_ovf});
			end
			held_cnt = 0;
			held_ovf = 1'b0;
		end
		items_taken++;
	endfunction

	// --- Checking ---

	task automatic report(input string msg);
		$display("ERROR @%0t result %0d: %s", $realtime, results_taken, msg);
		errors++;
	endtask

	task automatic check_sorted(input sorted_rec_t got);
		sorted_rec_t exp;
		if (sorted_q.size() == 0) begin
			report($sformatf("unexpected beat start=%0h end=%0h", got.arrive, got.depart));
		end else begin
			exp = sorted_q.pop_front();
			if (got.arrive !== exp.arrive)
				report($sformatf("sorted_start %0h, want %0h", got.arrive, exp.arrive));
			if (got.depart !== exp.depart)
				report($sformatf("sorted_end %0h, want %0h", got.depart, exp.depart));
			if (got.final_rec !== exp.final_rec)
				report($sformatf("final_record %b, want %b", got.final_rec, exp.final_rec));
			if (got.ovf !== exp.ovf)
				report($sformatf("overflowed %b, want %b", got.ovf, exp.ovf));
		end
	endtask

	// Monitor both channels at the edge. Check outputs first: a result can never
	// come from a record taken at the same edge.
	always @(posedge clk) begin : watch
		if (arst_n === 1'b1) begin
			if (srt_if.valid && srt_if.ready) begin
				check_sorted('{srt_if.sorted_start, srt_if.sorted_end,
					srt_if.final_record, srt_if.overflowed});
				results_taken++;
			end
			if (rec_if.valid && rec_if.ready)
				take_record('{rec_if.start_time, rec_if.end_time}, rec_if.last);
		end
	end

	// --- Stimulus helpers ---

	// Idle length: mostly none or short, now and then long; none while calm.
	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Time value: full random, a narrow range to force ties, an extreme, or a repeat.
	function automatic logic [TBITS-1:0] pick_time(logic [TBITS-1:0] prev);
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return TBITS'($urandom());
		if (r < 70)
			return TBITS'($urandom_range(0, 7));
		if (r < 80)
			return '0;
		if (r < 90)
			return TIME_MAX;
		return prev;
	endfunction

	// Offer one record beat after an optional gap; return at the edge that takes it.
	// Leave valid high so a following beat with no gap goes out back to back.
	task automatic push_record(input logic [TBITS-1:0] arr, input logic [TBITS-1:0] dep,
		input logic lst);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			rec_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec_if.valid      <= 1'b1;
		rec_if.start_time <= arr;
		rec_if.end_time   <= dep;
		rec_if.last       <= lst;
		items_sent++;
		do
			@(posedge clk);
		while (!rec_if.ready);
	endtask

	// --- Consumer: random back-pressure on the sorted channel ---
	// Once, after some results have come, hold ready low for a long stretch so the
	// output register stays full and the block stops taking record beats.
	initial begin : consumer
		int  gap;
		bit  held_off;
		held_off = 1'b0;
		srt_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = idle_len();
			if (!held_off && results_taken >= HOLD_AFTER) begin
				gap      = HOLD_CYCLES;
				held_off = 1'b1;
			end
			if (gap > 0) begin
				srt_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			srt_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!srt_if.valid);
		end
	end

	// --- Producer: directed table, then random sets ---
	initial begin : producer
		interval_t prev_rec;
		int        i, k, n, set_no;
		arst_n            <= 1'b0;
		rec_if.valid      <= 1'b0;
		rec_if.start_time <= '0;
		rec_if.end_time   <= '0;
		rec_if.last       <= 1'b0;
		prev_rec = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; pin typed results to their item number.
		for (i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].pinned)
				queue_pin(items_sent, plan[i].want);
			push_record(plan[i].arrive, plan[i].depart, plan[i].last);
		end

		// Pause the producer until every directed result has drained.
		rec_if.valid <= 1'b0;
		@(posedge clk);
		while (sorted_q.size() != 0)
			@(posedge clk);

		// Random sets. Mostly small; one fills the store exactly, and one runs past
		// it so several beats, the last one among them, are dropped.
		set_no = 0;
		while (items_sent < TOTAL_ITEMS) begin
			if (set_no == 2)
				n = CAPACITY;
			else if (set_no == 6)
				n = CAPACITY + 3;
			else if ($urandom_range(0, 9) < 7)
				n = $urandom_range(1, 6);
			else
				n = $urandom_range(7, 16);
			for (k = 0; k < n; k++) begin
				if (items_sent % 25 == 0)
					calm = ($urandom_range(0, 3) == 0);
				prev_rec.arrive = pick_time(prev_rec.arrive);
				prev_rec.depart = pick_time(prev_rec.depart);
				push_record(prev_rec.arrive, prev_rec.depart, k == n - 1);
			end
			set_no++;
		end

		// Drain: wait for every expected beat, then give the block time to misbehave.
		rec_if.valid <= 1'b0;
		@(posedge clk);
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
